[design/mctt_pkg.sv]
// Package for the multi-channel task timer.
// Holds command codes, field widths and the table write-port struct.
// No dependencies.
package mctt_pkg;

    localparam int TIME_W  = 32;
    localparam int CH_W    = 3;
    localparam int CNT_W   = 4;
    localparam int ACT_W   = 2;
    localparam int SWEEP_CAP = 8;

    localparam logic [ACT_W-1:0] ACT_TICK     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INIT     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ENABLE   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RESCHED  = 2'd3;

    typedef struct packed {
        logic              due_we;
        logic              per_we;
        logic [TIME_W-1:0] due_data;
        logic [TIME_W-1:0] per_data;
    } t_store_wr;

endpackage

[design/mctt_alu.sv]
// Shared 32-bit add/subtract unit of the task timer.
// Used for the due test and for both due-time updates.
// Depends on mctt_pkg.
module mctt_alu import mctt_pkg::*; (
    input  logic [TIME_W-1:0] i_a,
    input  logic [TIME_W-1:0] i_b,
    input  logic              i_sub,
    output logic [TIME_W-1:0] o_sum
);

    logic [TIME_W-1:0] w_b;

    assign w_b   = i_sub ? ~i_b : i_b;
    assign o_sum = i_a + w_b + {{(TIME_W-1){1'b0}}, i_sub};

endmodule

[design/mctt_store.sv]
// Due-time and period memories of the task timer, one write and one
// registered read per cycle; valid bits make never-written entries read zero.
// Depends on mctt_pkg.
module mctt_store import mctt_pkg::*; #(
    parameter int DEPTH = 8,
    parameter int IW    = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IW-1:0]     i_rd_addr,
    input  logic [IW-1:0]     i_wr_addr,
    input  t_store_wr         i_wr,
    output logic [TIME_W-1:0] o_rd_due,
    output logic [TIME_W-1:0] o_rd_per
);

    logic [TIME_W-1:0] r_due_mem [DEPTH];
    logic [TIME_W-1:0] r_per_mem [DEPTH];
    logic [DEPTH-1:0]  r_due_vld;
    logic [DEPTH-1:0]  r_per_vld;
    logic [TIME_W-1:0] r_rd_due;
    logic [TIME_W-1:0] r_rd_per;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_due_vld <= '0;
            r_per_vld <= '0;
        end else begin
            if (i_wr.due_we) begin
                r_due_vld[i_wr_addr] <= 1'b1;
            end
            if (i_wr.per_we) begin
                r_per_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.due_we) begin
            r_due_mem[i_wr_addr] <= i_wr.due_data;
        end
        if (i_wr.per_we) begin
            r_per_mem[i_wr_addr] <= i_wr.per_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_due <= r_due_vld[i_rd_addr] ? r_due_mem[i_rd_addr] : '0;
        r_rd_per <= r_per_vld[i_rd_addr] ? r_per_mem[i_rd_addr] : '0;
    end

    assign o_rd_due = r_rd_due;
    assign o_rd_per = r_rd_per;

endmodule

[design/multi_channel_task_timer_top.sv]
// Multi-channel task timer, top level: sequencer, channel flags, output beat.
// Depends on mctt_pkg, mctt_alu and mctt_store.
// Tick: each swept channel passes read, due test and update (the update waits
// while the output stalls), up to 8 channels; commands pass read and execute. One item at a time.
// Throughput set by the single shared adder and one table read port.
// Synchronous active-low reset clears all channels; no clearing pass.
module multi_channel_task_timer_top import mctt_pkg::*; #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [CH_W-1:0]   i_channel,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic [TIME_W-1:0] i_start_at_ms,
    input  logic [TIME_W-1:0] i_period_ms,
    input  logic              i_repeat_flag,
    input  logic              i_has_handler,
    input  logic              i_enable_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CH_W-1:0]   o_result_channel,
    output logic              o_fired,
    output logic [CNT_W-1:0]  o_fired_count,
    output logic              o_last
);

    localparam int IW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CAP = (NUM_CHANNELS < SWEEP_CAP) ? NUM_CHANNELS : SWEEP_CAP;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_CRD  = 3'd4;
    localparam logic [2:0] S_CEX  = 3'd5;

    logic [2:0]              r_state;
    logic [CNT_W-1:0]        r_active;
    logic [ACT_W-1:0]        r_action;
    logic [CH_W-1:0]         r_ch;
    logic [TIME_W-1:0]       r_now;
    logic [TIME_W-1:0]       r_start;
    logic [TIME_W-1:0]       r_period;
    logic                    r_rep_in;
    logic                    r_hnd_in;
    logic                    r_en_in;
    logic [CNT_W-1:0]        r_limit;
    logic [CH_W-1:0]         r_idx;
    logic [CNT_W-1:0]        r_count;
    logic                    r_fire;
    logic [NUM_CHANNELS-1:0] r_en;
    logic [NUM_CHANNELS-1:0] r_rep;
    logic [NUM_CHANNELS-1:0] r_hnd;

    logic                    r_out_valid;
    logic [CH_W-1:0]         r_out_ch;
    logic                    r_out_fired;
    logic [CNT_W-1:0]        r_out_count;
    logic                    r_out_last;

    logic                    w_accept;
    logic                    w_out_free;
    logic [CNT_W-1:0]        w_limit;
    logic [IW+2:0]           w_sweep_ext;
    logic [IW+2:0]           w_ch_ext;
    logic [IW-1:0]           w_sweep_addr;
    logic [IW-1:0]           w_ch_addr;
    logic [IW-1:0]           w_addr;
    logic                    w_ch_ok;
    logic                    w_is_cmd;
    logic                    w_last_ch;
    logic [CNT_W-1:0]        w_count_nx;
    logic [TIME_W-1:0]       w_rd_due;
    logic [TIME_W-1:0]       w_rd_per;
    logic [TIME_W-1:0]       w_alu_a;
    logic [TIME_W-1:0]       w_alu_b;
    logic                    w_alu_sub;
    logic [TIME_W-1:0]       w_alu_sum;
    t_store_wr               w_wr;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_limit = (r_active > CNT_W'(CAP)) ? CNT_W'(CAP) : r_active;

    assign w_sweep_ext  = {{IW{1'b0}}, r_idx};
    assign w_ch_ext     = {{IW{1'b0}}, r_ch};
    assign w_sweep_addr = w_sweep_ext[IW-1:0];
    assign w_ch_addr    = w_ch_ext[IW-1:0];
    assign w_is_cmd     = (r_state == S_CRD) || (r_state == S_CEX);
    assign w_addr       = w_is_cmd ? w_ch_addr : w_sweep_addr;
    assign w_ch_ok      = (int'(r_ch) < NUM_CHANNELS);
    assign w_last_ch    = ({1'b0, r_idx} + CNT_W'(1)) == r_limit;
    assign w_count_nx   = r_count + {{(CNT_W-1){1'b0}}, r_fire};

    always_comb begin
        w_alu_a   = r_now;
        w_alu_b   = w_rd_per;
        w_alu_sub = 1'b0;
        if (r_state == S_CHK) begin
            w_alu_b   = w_rd_due;
            w_alu_sub = 1'b1;
        end else if (r_state == S_UPD) begin
            w_alu_a = w_rd_due;
        end
    end

    mctt_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .i_sub (w_alu_sub),
        .o_sum (w_alu_sum)
    );

    always_comb begin
        w_wr.due_we   = 1'b0;
        w_wr.per_we   = 1'b0;
        w_wr.due_data = w_alu_sum;
        w_wr.per_data = r_period;
        if (r_state == S_UPD && w_out_free && r_fire && r_rep[w_sweep_addr]) begin
            w_wr.due_we = 1'b1;
        end else if (r_state == S_CEX && w_out_free && w_ch_ok) begin
            if (r_action == ACT_INIT) begin
                w_wr.due_we   = 1'b1;
                w_wr.per_we   = 1'b1;
                w_wr.due_data = r_start;
            end else if (r_action == ACT_RESCHED) begin
                w_wr.due_we = 1'b1;
            end
        end
    end

    mctt_store #(
        .DEPTH (NUM_CHANNELS),
        .IW    (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_addr),
        .i_wr_addr (w_addr),
        .i_wr      (w_wr),
        .o_rd_due  (w_rd_due),
        .o_rd_per  (w_rd_per)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_ch     <= i_channel;
            r_now    <= i_now_ms;
            r_start  <= i_start_at_ms;
            r_period <= i_period_ms;
            r_rep_in <= i_repeat_flag;
            r_hnd_in <= i_has_handler;
            r_en_in  <= i_enable_value;
            r_limit  <= w_limit;
        end
        if (r_state == S_CHK) begin
            r_fire <= r_en[w_sweep_addr] && r_hnd[w_sweep_addr] && !w_alu_sum[TIME_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_count     <= '0;
            r_en        <= '0;
            r_rep       <= '0;
            r_hnd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= (r_state == S_UPD) || (r_state == S_CEX);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_idx   <= '0;
                        r_count <= '0;
                        if (i_action != ACT_TICK) begin
                            r_state <= S_CRD;
                        end else if (w_limit != '0) begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_out_free) begin
                        if (r_fire && !r_rep[w_sweep_addr]) begin
                            r_en[w_sweep_addr] <= 1'b0;
                        end
                        r_count     <= w_count_nx;
                        r_out_ch    <= r_idx;
                        r_out_fired <= r_fire;
                        r_out_count <= w_count_nx;
                        r_out_last  <= w_last_ch;
                        if (w_last_ch) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + CH_W'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_CRD: begin
                    r_state <= S_CEX;
                end
                S_CEX: begin
                    if (w_out_free) begin
                        if (w_ch_ok) begin
                            if (r_action == ACT_INIT) begin
                                r_en[w_ch_addr]  <= 1'b1;
                                r_rep[w_ch_addr] <= r_rep_in;
                                r_hnd[w_ch_addr] <= r_hnd_in;
                            end else if (r_action == ACT_ENABLE) begin
                                r_en[w_ch_addr] <= r_en_in;
                            end
                        end
                        r_out_ch    <= r_ch;
                        r_out_fired <= 1'b0;
                        r_out_count <= '0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_channel = r_out_ch;
    assign o_fired          = r_out_fired;
    assign o_fired_count    = r_out_count;
    assign o_last           = r_out_last;

endmodule
